FILE: src/lcg48_pkg.sv
// Shared types, constants and codes of the rand48 lane bank.
package lcg48_pkg;

    // Number of generator lanes in the bank and the address width of the state memory.
    localparam int LANES   = 1024;
    localparam int LANE_AW = (LANES > 1) ? $clog2(LANES) : 1;

    localparam int STATE_W = 48;

    // Generator constants.
    localparam logic [34:0] LCG_MUL  = 35'h5DEECE66D;
    localparam logic [3:0]  LCG_ADD  = 4'hB;
    localparam logic [15:0] SEED_LOW = 16'h330E;

    // Func codes of an input item.
    localparam logic [2:0] FUNC_SEED     = 3'd0;
    localparam logic [2:0] FUNC_SEED_MUL = 3'd1;
    localparam logic [2:0] FUNC_ADVANCE  = 3'd2;
    localparam logic [2:0] FUNC_UNS31    = 3'd3;
    localparam logic [2:0] FUNC_SGN32    = 3'd4;
    localparam logic [2:0] FUNC_FLOAT    = 3'd5;

    // Normalization runs one binary shift step per cycle: 16, 8, 4, 2, 1.
    localparam int          NORM_STEPS = 5;
    localparam logic [2:0]  NORM_LAST  = 3'(NORM_STEPS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEED,
        S_READ,
        S_MUL,
        S_ADD,
        S_NORM,
        S_OUT
    } t_state;

    // Controller to datapath.
    typedef struct packed {
        logic       ld_item;
        logic       ram_rd;
        logic       seed_wr;
        logic       ld_pp;
        logic       upd_state;
        logic       norm_en;
        logic [2:0] norm_step;
        logic       ld_out;
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic in_ok;
        logic in_seed;
        logic adv_only;
        logic is_float;
        logic out_full;
    } t_sts;

endpackage

FILE: src/lcg48_if.sv
// Handshake channels of the rand48 lane bank: request and response.
interface lcg48_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  func;
    logic [9:0]  lane;
    logic [31:0] seed_value;

    modport source (output valid, output func, output lane, output seed_value, input ready);
    modport sink   (input valid, input func, input lane, input seed_value, output ready);
endinterface

interface lcg48_rsp_if;
    logic        valid;
    logic        ready;
    logic [9:0]  lane_out;
    logic [31:0] random_word;

    modport source (output valid, output lane_out, output random_word, input ready);
    modport sink   (input valid, input lane_out, input random_word, output ready);
endinterface

FILE: src/lcg48_ram.sv
// Generic simple dual-port RAM with registered read.
module lcg48_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/lcg48_ctrl.sv
// Sequencing state machine of the rand48 lane bank.
module lcg48_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  lcg48_pkg::t_sts  i_sts,
    output lcg48_pkg::t_cmd  o_cmd
);

    lcg48_pkg::t_state r_state, n_state;
    logic [2:0]        r_step, n_step;
    logic              accept;

    assign accept = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lcg48_pkg::S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        n_step  = '0;
        unique case (r_state)
            lcg48_pkg::S_IDLE: begin
                if (accept && i_sts.in_ok) begin
                    n_state = i_sts.in_seed ? lcg48_pkg::S_SEED : lcg48_pkg::S_READ;
                end
            end
            lcg48_pkg::S_SEED: n_state = lcg48_pkg::S_IDLE;
            lcg48_pkg::S_READ: n_state = lcg48_pkg::S_MUL;
            lcg48_pkg::S_MUL:  n_state = lcg48_pkg::S_ADD;
            lcg48_pkg::S_ADD: begin
                priority if (i_sts.adv_only) begin
                    n_state = lcg48_pkg::S_IDLE;
                end else if (i_sts.is_float) begin
                    n_state = lcg48_pkg::S_NORM;
                end else begin
                    n_state = lcg48_pkg::S_OUT;
                end
            end
            lcg48_pkg::S_NORM: begin
                n_step = r_step + 3'd1;
                if (r_step == lcg48_pkg::NORM_LAST) begin
                    n_state = lcg48_pkg::S_OUT;
                    n_step  = '0;
                end
            end
            lcg48_pkg::S_OUT: begin
                if (!i_sts.out_full) begin
                    n_state = lcg48_pkg::S_IDLE;
                end
            end
            default: n_state = lcg48_pkg::S_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        o_cmd           = '0;
        o_cmd.norm_step = r_step;
        o_in_ready      = 1'b0;
        unique case (r_state)
            lcg48_pkg::S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.ld_item = accept;
                o_cmd.ram_rd  = accept && i_sts.in_ok && !i_sts.in_seed;
            end
            lcg48_pkg::S_SEED: o_cmd.seed_wr   = 1'b1;
            lcg48_pkg::S_READ: o_cmd.ld_pp     = 1'b0;
            lcg48_pkg::S_MUL:  o_cmd.ld_pp     = 1'b1;
            lcg48_pkg::S_ADD:  o_cmd.upd_state = 1'b1;
            lcg48_pkg::S_NORM: o_cmd.norm_en   = 1'b1;
            lcg48_pkg::S_OUT:  o_cmd.ld_out    = !i_sts.out_full;
            default:           o_cmd           = '0;
        endcase
    end

endmodule

FILE: src/lcg48_dp.sv
// Datapath of the rand48 lane bank: item registers, state memory, LCG step and output register.
module lcg48_dp (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [2:0]       i_func,
    input  logic [9:0]       i_lane,
    input  logic [31:0]      i_seed_value,
    input  lcg48_pkg::t_cmd  i_cmd,
    output lcg48_pkg::t_sts  o_sts,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [9:0]       o_lane_out,
    output logic [31:0]      o_random_word
);

    logic [2:0]  r_func;
    logic [9:0]  r_lane;
    logic [31:0] r_seed;

    logic [lcg48_pkg::STATE_W-1:0] ram_rdata;
    logic [lcg48_pkg::STATE_W-1:0] ram_wdata;
    logic                          ram_we;

    logic [lcg48_pkg::STATE_W-1:0] r_pp_lo;
    logic [15:0]                   r_pp_hi;
    logic [lcg48_pkg::STATE_W-1:0] r_state;
    logic [lcg48_pkg::STATE_W-1:0] next_state;
    logic [lcg48_pkg::STATE_W-1:0] seed_state;

    logic [23:0] r_norm_m, n_norm_m;
    logic [4:0]  r_norm_z, n_norm_z;

    logic        r_out_valid;
    logic [9:0]  r_out_lane;
    logic [31:0] r_out_word;
    logic [31:0] word;
    logic [31:0] float_word;
    logic [31:0] seed_prod;

    assign o_sts.in_ok    = (i_func <= lcg48_pkg::FUNC_FLOAT)
                         && (17'(i_lane) < 17'(lcg48_pkg::LANES));
    assign o_sts.in_seed  = (i_func == lcg48_pkg::FUNC_SEED)
                         || (i_func == lcg48_pkg::FUNC_SEED_MUL);
    assign o_sts.adv_only = (r_func == lcg48_pkg::FUNC_ADVANCE);
    assign o_sts.is_float = (r_func == lcg48_pkg::FUNC_FLOAT);
    assign o_sts.out_full = r_out_valid && !i_out_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_item) begin
            r_func <= i_func;
            r_lane <= i_lane;
            r_seed <= i_seed_value;
        end
    end

    // Only the low 32 bits of the lane times seed product are kept.
    assign seed_prod  = 32'({22'b0, r_lane} * r_seed);
    assign seed_state = (r_func == lcg48_pkg::FUNC_SEED_MUL)
                      ? {seed_prod, lcg48_pkg::SEED_LOW}
                      : {r_seed, lcg48_pkg::SEED_LOW};

    // Product mod 2^48 split into a 32x32 term and two 16-bit terms that land at bit 32.
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_pp) begin
            r_pp_lo <= {16'b0, ram_rdata[31:0]} * {16'b0, lcg48_pkg::LCG_MUL[31:0]};
            r_pp_hi <= 16'(ram_rdata[15:0] * 16'(lcg48_pkg::LCG_MUL[34:32]))
                     + 16'(ram_rdata[47:32] * lcg48_pkg::LCG_MUL[15:0]);
        end
    end

    assign next_state = r_pp_lo + {r_pp_hi, 32'b0} + 48'(lcg48_pkg::LCG_ADD);

    assign ram_we    = i_cmd.seed_wr || i_cmd.upd_state;
    assign ram_wdata = i_cmd.seed_wr ? seed_state : next_state;

    lcg48_ram #(
        .WIDTH (lcg48_pkg::STATE_W),
        .DEPTH (lcg48_pkg::LANES),
        .AW    (lcg48_pkg::LANE_AW)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (lcg48_pkg::LANE_AW'(r_lane)),
        .i_wdata (ram_wdata),
        .i_re    (i_cmd.ram_rd),
        .i_raddr (lcg48_pkg::LANE_AW'(i_lane)),
        .o_rdata (ram_rdata)
    );

    // Leading-zero normalization of bits 47..24, one binary step per cycle.
    always_comb begin
        n_norm_m = r_norm_m;
        n_norm_z = r_norm_z;
        unique case (i_cmd.norm_step)
            3'd0: if (r_norm_m[23:8] == '0) begin
                n_norm_m = {r_norm_m[7:0], 16'b0};
                n_norm_z = r_norm_z + 5'd16;
            end
            3'd1: if (r_norm_m[23:16] == '0) begin
                n_norm_m = {r_norm_m[15:0], 8'b0};
                n_norm_z = r_norm_z + 5'd8;
            end
            3'd2: if (r_norm_m[23:20] == '0) begin
                n_norm_m = {r_norm_m[19:0], 4'b0};
                n_norm_z = r_norm_z + 5'd4;
            end
            3'd3: if (r_norm_m[23:22] == '0) begin
                n_norm_m = {r_norm_m[21:0], 2'b0};
                n_norm_z = r_norm_z + 5'd2;
            end
            3'd4: if (!r_norm_m[23]) begin
                n_norm_m = {r_norm_m[22:0], 1'b0};
                n_norm_z = r_norm_z + 5'd1;
            end
            default: begin
                n_norm_m = r_norm_m;
                n_norm_z = r_norm_z;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.upd_state) begin
            r_state  <= next_state;
            r_norm_m <= next_state[47:24];
            r_norm_z <= '0;
        end else if (i_cmd.norm_en) begin
            r_norm_m <= n_norm_m;
            r_norm_z <= n_norm_z;
        end
    end

    // A zero integer stays zero after normalization and encodes as +0.
    assign float_word = (r_norm_m == '0) ? 32'b0
                      : {1'b0, 8'd126 - {3'b0, r_norm_z}, r_norm_m[22:0]};

    always_comb begin
        unique case (r_func)
            lcg48_pkg::FUNC_UNS31: word = {1'b0, r_state[47:17]};
            lcg48_pkg::FUNC_SGN32: word = r_state[47:16];
            default:               word = float_word;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.ld_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_out) begin
            r_out_lane <= r_lane;
            r_out_word <= word;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_lane_out    = r_out_lane;
    assign o_random_word = r_out_word;

endmodule

FILE: src/lcg48_lane_bank_top.sv
// Top level of the rand48 lane bank: controller, datapath and channel wiring.
//
//  channel  dir  payload                      item
//  i_in     in   func, lane, seed_value       one request for one lane
//  o_out    out  lane_out, random_word        one random word (funcs 3 to 5)
//
// One item is in work at a time. An ignored item is dropped when taken and a seed is written
// without a memory read; the other funcs go through the registered memory read and the split
// 48-bit multiply, and a float word adds one normalize step per cycle.
// The output register holds a result until it is taken; the next item is accepted meanwhile.
// A new result waits while the previous one is still untaken. Reset is synchronous and
// clears control only; lane state is undefined until a lane is seeded.
module lcg48_lane_bank_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    lcg48_req_if.sink          i_in,
    lcg48_rsp_if.source        o_out
);

    lcg48_pkg::t_cmd cmd;
    lcg48_pkg::t_sts sts;
    logic            in_ready;

    lcg48_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    lcg48_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_func        (i_in.func),
        .i_lane        (i_in.lane),
        .i_seed_value  (i_in.seed_value),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_out_valid   (o_out.valid),
        .i_out_ready   (o_out.ready),
        .o_lane_out    (o_out.lane_out),
        .o_random_word (o_out.random_word)
    );

    assign i_in.ready = in_ready;

endmodule

FILE: verif/tb.sv
// Self-checking testbench of the rand48 lane bank: directed and random items against a predictor.
module tb;

    localparam logic [2:0]  FUNC_SPARE_A = 3'd6;
    localparam logic [2:0]  FUNC_SPARE_B = 3'd7;
    localparam logic [47:0] GEN_MUL      = 48'h5DEECE66D;
    localparam logic [47:0] GEN_INC      = 48'hB;
    localparam logic [15:0] GEN_TAIL     = 16'h330E;
    localparam int          POOL_SIZE    = 16;
    localparam int          STALL_LIMIT  = 2000;
    localparam int          DRAIN_CYCLES = 40;
    localparam int          MAX_REPORTS  = 50;

    typedef struct {
        logic [9:0]  lane;
        logic [31:0] word;
    } t_rand_word;

    logic clk = 1'b0;
    logic rst_n;

    lcg48_req_if req_ch ();
    lcg48_rsp_if rsp_ch ();

    logic [47:0] gen_state [lcg48_pkg::LANES];
    t_rand_word  pending_words [$];
    logic [9:0]  lane_pool [POOL_SIZE];
    int          errors        = 0;
    int          send_idle_pct = 0;
    int          rsp_stall_pct = 0;
    int          stall_left    = 0;

    lcg48_lane_bank_top DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (req_ch),
        .o_out   (rsp_ch)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (errors < MAX_REPORTS)
            $display("ERROR %s: got 0x%0h, expected 0x%0h", what, got, want);
        errors++;
    endtask

    // Exact single-precision encoding of m * 2^-24.
    function automatic logic [31:0] unit_float(input logic [23:0] m);
        int p;
        if (m == 24'd0)
            return 32'd0;
        p = 23;
        while (!m[p])
            p--;
        return {1'b0, 8'(p + 103), 23'(m << (23 - p))};
    endfunction

    function automatic void predict_item(input logic [2:0] f, input logic [9:0] ln,
                                         input logic [31:0] sv);
        logic [47:0] s;
        t_rand_word  r;
        case (f)
            lcg48_pkg::FUNC_SEED:     gen_state[ln] = {sv, GEN_TAIL};
            lcg48_pkg::FUNC_SEED_MUL: gen_state[ln] = {32'(ln * sv), GEN_TAIL};
            lcg48_pkg::FUNC_ADVANCE, lcg48_pkg::FUNC_UNS31, lcg48_pkg::FUNC_SGN32,
            lcg48_pkg::FUNC_FLOAT: begin
                s = gen_state[ln] * GEN_MUL + GEN_INC;
                gen_state[ln] = s;
                r.lane = ln;
                case (f)
                    lcg48_pkg::FUNC_UNS31: r.word = {1'b0, s[47:17]};
                    lcg48_pkg::FUNC_SGN32: r.word = s[47:16];
                    default:               r.word = unit_float(s[47:24]);
                endcase
                if (f != lcg48_pkg::FUNC_ADVANCE)
                    pending_words.push_back(r);
            end
            default: ;
        endcase
    endfunction

    // Seed word whose first advance lands on a state with the given top 32 bits.
    // The low 16 bits of that state are fixed by the seed tail, so the generator
    // multiplier is inverted modulo 2^48 to walk one step back.
    function automatic logic [31:0] seed_reaching(input logic [31:0] top);
        logic [47:0] inv;
        logic [47:0] target;
        logic [47:0] start;
        inv = GEN_MUL;
        repeat (5)
            inv = inv * (48'd2 - GEN_MUL * inv);
        target = {top, 16'(GEN_TAIL * GEN_MUL + GEN_INC)};
        start  = (target - GEN_INC) * inv;
        return start[47:16];
    endfunction

    function automatic int pick_gap();
        return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 40);
    endfunction

    function automatic logic [31:0] pick_seed();
        case ($urandom_range(0, 7))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    // Called at a rising edge; returns at the edge where the item is taken.
    task automatic send_item(input logic [2:0] f, input logic [9:0] ln, input logic [31:0] sv);
        int gap;
        gap = ($urandom_range(0, 99) < send_idle_pct) ? pick_gap() : 0;
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.func       <= f;
        req_ch.lane       <= ln;
        req_ch.seed_value <= sv;
        @(posedge clk);
        while (req_ch.ready !== 1'b1)
            @(posedge clk);
        predict_item(f, ln, sv);
    endtask

    task automatic wait_results_drained();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_words.size() != 0)
            @(posedge clk);
    endtask

    // Lanes in the pool are always seeded, so advances never touch an unwritten lane.
    task automatic random_item(output bit counted);
        int         pick;
        int         slot;
        logic [2:0] f;
        logic [9:0] ln;
        pick = $urandom_range(0, 99);
        slot = $urandom_range(0, POOL_SIZE - 1);
        ln   = lane_pool[slot];
        f    = lcg48_pkg::FUNC_UNS31 + 3'($urandom_range(0, 2));
        if (pick < 4) begin
            ln = 10'($urandom_range(0, lcg48_pkg::LANES - 1));
            lane_pool[slot] = ln;
            f = pick[0] ? lcg48_pkg::FUNC_SEED_MUL : lcg48_pkg::FUNC_SEED;
        end else if (pick < 12)
            f = lcg48_pkg::FUNC_SEED;
        else if (pick < 16)
            f = lcg48_pkg::FUNC_SEED_MUL;
        else if (pick < 26)
            f = lcg48_pkg::FUNC_ADVANCE;
        else if (pick >= 96) begin
            f  = pick[0] ? FUNC_SPARE_A : FUNC_SPARE_B;
            ln = 10'($urandom());
        end
        counted = (f <= lcg48_pkg::FUNC_FLOAT);
        send_item(f, ln, pick_seed());
    endtask

    task automatic run_random_items(input int n);
        int done;
        bit counted;
        done = 0;
        while (done < n) begin
            random_item(counted);
            if (counted)
                done++;
        end
    endtask

    task automatic test_output_extremes();
        send_idle_pct = 30;
        rsp_stall_pct = 30;
        // A zero integer part must come out as the all-zero float.
        send_item(lcg48_pkg::FUNC_SEED, 10'd0, seed_reaching(32'h0000_0000));
        send_item(lcg48_pkg::FUNC_FLOAT, 10'd0, 32'h0);
        send_item(lcg48_pkg::FUNC_SEED, 10'd1, seed_reaching(32'h0100_0000));
        send_item(lcg48_pkg::FUNC_FLOAT, 10'd1, 32'hFFFF_FFFF);
        send_item(lcg48_pkg::FUNC_SEED, 10'd1023, seed_reaching(32'hFFFF_FFFF));
        send_item(lcg48_pkg::FUNC_SGN32, 10'd1023, 32'h0);
        send_item(lcg48_pkg::FUNC_SEED, 10'd512, seed_reaching(32'hFFFF_FFFF));
        send_item(lcg48_pkg::FUNC_UNS31, 10'd512, 32'h0);
        send_item(lcg48_pkg::FUNC_SEED, 10'd2, seed_reaching(32'h0000_0000));
        send_item(lcg48_pkg::FUNC_UNS31, 10'd2, 32'h0);
        wait_results_drained();
    endtask

    task automatic test_seed_funcs();
        send_item(lcg48_pkg::FUNC_SEED_MUL, 10'd1023, 32'hFFFF_FFFF);
        send_item(lcg48_pkg::FUNC_SGN32, 10'd1023, 32'h0);
        send_item(lcg48_pkg::FUNC_ADVANCE, 10'd1023, 32'h0);
        send_item(lcg48_pkg::FUNC_FLOAT, 10'd1023, 32'h0);
        send_item(lcg48_pkg::FUNC_SEED_MUL, 10'd0, 32'hDEAD_BEEF);
        send_item(lcg48_pkg::FUNC_UNS31, 10'd0, 32'h0);
        send_item(lcg48_pkg::FUNC_SEED, 10'd3, 32'h0000_0000);
        send_item(lcg48_pkg::FUNC_SEED, 10'd4, 32'hFFFF_FFFF);
        send_item(lcg48_pkg::FUNC_ADVANCE, 10'd3, 32'h0);
        send_item(lcg48_pkg::FUNC_SGN32, 10'd4, 32'h0);
        wait_results_drained();
    endtask

    task automatic test_ignored_funcs();
        send_item(FUNC_SPARE_A, 10'd5, $urandom());
        send_item(FUNC_SPARE_B, 10'd1023, 32'hFFFF_FFFF);
        wait_results_drained();
    endtask

    task automatic test_same_lane_burst();
        send_idle_pct = 0;
        rsp_stall_pct = 0;
        send_item(lcg48_pkg::FUNC_UNS31, 10'd1023, 32'h0);
        send_item(lcg48_pkg::FUNC_UNS31, 10'd1023, 32'h0);
        wait_results_drained();
    endtask

    task automatic test_random_mixed();
        send_idle_pct = 25;
        rsp_stall_pct = 25;
        for (int i = 0; i < POOL_SIZE; i++) begin
            lane_pool[i] = (i == 0) ? 10'd0 :
                           (i == 1) ? 10'(lcg48_pkg::LANES - 1) :
                                      10'($urandom_range(0, lcg48_pkg::LANES - 1));
            send_item(lcg48_pkg::FUNC_SEED, lane_pool[i], $urandom());
        end
        run_random_items(1200);
        wait_results_drained();
    endtask

    task automatic test_random_full_rate();
        send_idle_pct = 0;
        rsp_stall_pct = 0;
        run_random_items(300);
        wait_results_drained();
    endtask

    task automatic test_random_output_backpressure();
        send_idle_pct = 10;
        rsp_stall_pct = 60;
        run_random_items(300);
        wait_results_drained();
    endtask

    always @(posedge clk) begin
        if (stall_left > 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end else if ($urandom_range(0, 99) < rsp_stall_pct) begin
            rsp_ch.ready <= 1'b0;
            stall_left   <= pick_gap() - 1;
        end else begin
            rsp_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk) begin : result_check
        t_rand_word want;
        if (rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            if (pending_words.size() == 0) begin
                report_mismatch("result with none expected, lane", 32'(rsp_ch.lane_out), '0);
            end else begin
                want = pending_words.pop_front();
                if (rsp_ch.lane_out !== want.lane)
                    report_mismatch("lane_out", 32'(rsp_ch.lane_out), 32'(want.lane));
                if (rsp_ch.random_word !== want.word)
                    report_mismatch("random_word", rsp_ch.random_word, want.word);
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge clk);
            if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
                (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
                quiet = 0;
            else
                quiet++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        rst_n             = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.func       = lcg48_pkg::FUNC_SEED;
        req_ch.lane       = '0;
        req_ch.seed_value = '0;
        rsp_ch.ready      = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_output_extremes();
        test_seed_funcs();
        test_ignored_funcs();
        test_same_lane_burst();
        test_random_mixed();
        test_random_full_rate();
        test_random_output_backpressure();

        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_words.size() != 0)
            report_mismatch("results never delivered", 32'(pending_words.size()), '0);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

FILE: sim.f
src/lcg48_pkg.sv
src/lcg48_if.sv
src/lcg48_ram.sv
src/lcg48_ctrl.sv
src/lcg48_dp.sv
src/lcg48_lane_bank_top.sv
verif/tb.sv
